/* src/rpsr_pkg.sv */
package rpsr_pkg;

  localparam int MAX_COPIES = 8;
  localparam int NUM_SEQ    = 8;
  localparam int COPY_CAP   = (MAX_COPIES < NUM_SEQ) ? MAX_COPIES : NUM_SEQ;
  localparam int LANE_N     = COPY_CAP - 1;
  localparam int IDX_W      = $clog2(NUM_SEQ);
  localparam int FACTOR_W   = 4;
  localparam int SEQ_W      = 16;
  localparam int CNT_W      = 32;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1);

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] lost;
    logic [CNT_W-1:0] ooo;
    logic [CNT_W-1:0] revived;
  } stats_t;

  typedef struct packed {
    idx_t   start;
    stats_t stats;
  } job_t;

endpackage

/* src/rpsr_lane.sv */
module rpsr_lane (
  input  rpsr_pkg::seq_t           seq,
  input  logic [rpsr_pkg::SEQ_W:0] successor,
  input  logic                     en,
  output logic                     match
);

  assign match = en && ({1'b0, seq} == successor);

endmodule

/* src/rpsr_merge.sv */
module rpsr_merge (
  input  logic [rpsr_pkg::LANE_N-1:0] match,
  input  rpsr_pkg::idx_t              fm1,
  output rpsr_pkg::idx_t              start
);

  always_comb begin
    start = fm1;
    for (int j = rpsr_pkg::LANE_N - 1; j >= 0; j--) begin
      if (match[j]) begin
        start = rpsr_pkg::IDX_W'(j);
      end
    end
  end

endmodule

/* src/rpsr_stats.sv */
module rpsr_stats (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  rpsr_pkg::seq_t   seq0,
  input  rpsr_pkg::idx_t   start,
  output rpsr_pkg::seq_t   last_seq,
  output logic             drop,
  output rpsr_pkg::stats_t stats_upd
);

  rpsr_pkg::seq_t   last_r, last_nxt;
  rpsr_pkg::stats_t stats_r, stats_nxt;
  rpsr_pkg::seq_t   gap;
  logic             have_last;

  assign last_seq  = last_r;
  assign have_last = (last_r != '0);
  assign gap       = seq0 - last_r - rpsr_pkg::SEQ_W'(1);
  assign drop      = have_last && gap[rpsr_pkg::SEQ_W-1];

  always_comb begin
    stats_upd = stats_r;
    if (drop) begin
      stats_upd.ooo = stats_r.ooo + rpsr_pkg::CNT_W'(1);
    end else begin
      if (have_last) begin
        stats_upd.lost  = stats_r.lost + rpsr_pkg::CNT_W'(gap);
        stats_upd.total = stats_r.total + rpsr_pkg::CNT_W'(gap) + rpsr_pkg::CNT_W'(1);
      end
      stats_upd.revived = stats_r.revived + rpsr_pkg::CNT_W'(start);
    end
  end

  always_comb begin
    last_nxt  = last_r;
    stats_nxt = stats_r;
    if (accept) begin
      stats_nxt = stats_upd;
      if (!drop) begin
        last_nxt = seq0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      stats_r <= '0;
    end else begin
      last_r  <= last_nxt;
      stats_r <= stats_nxt;
    end
  end

endmodule

/* src/rpsr_emit.sv */
module rpsr_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  input  rpsr_pkg::job_t               job,
  output logic                         job_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rpsr_pkg::idx_t               out_copy_index,
  output logic                         out_last_of_run,
  output logic [rpsr_pkg::CNT_W-1:0]   out_total_count,
  output logic [rpsr_pkg::CNT_W-1:0]   out_lost_count,
  output logic [rpsr_pkg::CNT_W-1:0]   out_out_of_order_count,
  output logic [rpsr_pkg::CNT_W-1:0]   out_revived_count
);

  logic             cur_valid_r, cur_valid_nxt;
  rpsr_pkg::idx_t   cur_idx_r, cur_idx_nxt;
  rpsr_pkg::stats_t cur_stats_r, cur_stats_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  rpsr_pkg::job_t   pend_job_r, pend_job_nxt;
  logic             cur_free, job_take;

  assign job_ready = !pend_valid_r;
  assign job_take  = job_valid && job_ready;
  assign cur_free  = !cur_valid_r || (out_ready && (cur_idx_r == '0));

  always_comb begin
    cur_valid_nxt  = cur_valid_r;
    cur_idx_nxt    = cur_idx_r;
    cur_stats_nxt  = cur_stats_r;
    pend_valid_nxt = pend_valid_r;
    pend_job_nxt   = pend_job_r;
    if (cur_free) begin
      if (pend_valid_r) begin
        cur_valid_nxt  = 1'b1;
        cur_idx_nxt    = pend_job_r.start;
        cur_stats_nxt  = pend_job_r.stats;
        pend_valid_nxt = 1'b0;
      end else if (job_take) begin
        cur_valid_nxt = 1'b1;
        cur_idx_nxt   = job.start;
        cur_stats_nxt = job.stats;
      end else begin
        cur_valid_nxt = 1'b0;
      end
    end else if (out_ready) begin
      cur_idx_nxt = cur_idx_r - rpsr_pkg::IDX_W'(1);
      if (job_take) begin
        pend_valid_nxt = 1'b1;
        pend_job_nxt   = job;
      end
    end else if (job_take) begin
      pend_valid_nxt = 1'b1;
      pend_job_nxt   = job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      cur_valid_r  <= cur_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
    cur_idx_r   <= cur_idx_nxt;
    cur_stats_r <= cur_stats_nxt;
    pend_job_r  <= pend_job_nxt;
  end

  assign out_valid              = cur_valid_r;
  assign out_copy_index         = cur_idx_r;
  assign out_last_of_run        = (cur_idx_r == '0);
  assign out_total_count        = cur_stats_r.total;
  assign out_lost_count         = cur_stats_r.lost;
  assign out_out_of_order_count = cur_stats_r.ooo;
  assign out_revived_count      = cur_stats_r.revived;

  a_pend_needs_cur: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> cur_valid_r)
    else $error("pending job without an active job");

  a_index_steps_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && (out_copy_index != '0)) |=>
      (out_valid && (out_copy_index == $past(out_copy_index) - rpsr_pkg::IDX_W'(1))))
    else $error("copy index did not step down by one");

  a_run_keeps_stats: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_run) |=> $stable(cur_stats_r))
    else $error("counters changed inside one run");

  a_busy_take_pends: assert property (@(posedge clk) disable iff (!rst_n)
    (job_take && !cur_free) |=> pend_valid_r)
    else $error("job taken while busy was not held");

endmodule

/* src/redundant_packet_sequence_recovery.sv */
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | in_seq_copy_0 .. in_seq_copy_7
// out     | output    | out_valid / out_ready  | out_copy_index, out_last_of_run, counters
// cfg     | input     | cfg_valid / cfg_ready  | cfg_data (redundancy factor)
//
// An accepted item updates the counters in its accept cycle and yields start+1 items,
// one per cycle on the output register while out_ready is high, 1 to factor in all.
// A dropped (out of order) item yields no output item. One job is held behind the active
// run, so the next item is taken while results still wait. Reset is synchronous,
// active low; counters and the last sequence clear, factor returns to one.
module redundant_packet_sequence_recovery (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rpsr_pkg::SEQ_W-1:0]      in_seq_copy_0,
  input  logic [rpsr_pkg::SEQ_W-1:0]      in_seq_copy_1,
  input  logic [rpsr_pkg::SEQ_W-1:0]      in_seq_copy_2,
  input  logic [rpsr_pkg::SEQ_W-1:0]      in_seq_copy_3,
  input  logic [rpsr_pkg::SEQ_W-1:0]      in_seq_copy_4,
  input  logic [rpsr_pkg::SEQ_W-1:0]      in_seq_copy_5,
  input  logic [rpsr_pkg::SEQ_W-1:0]      in_seq_copy_6,
  input  logic [rpsr_pkg::SEQ_W-1:0]      in_seq_copy_7,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rpsr_pkg::IDX_W-1:0]      out_copy_index,
  output logic                            out_last_of_run,
  output logic [rpsr_pkg::CNT_W-1:0]      out_total_count,
  output logic [rpsr_pkg::CNT_W-1:0]      out_lost_count,
  output logic [rpsr_pkg::CNT_W-1:0]      out_out_of_order_count,
  output logic [rpsr_pkg::CNT_W-1:0]      out_revived_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rpsr_pkg::FACTOR_W-1:0]   cfg_data
);

  logic [rpsr_pkg::FACTOR_W-1:0] factor_r, factor_nxt;
  logic [rpsr_pkg::FACTOR_W-1:0] f_eff;
  rpsr_pkg::idx_t                fm1;
  rpsr_pkg::seq_t                seq [rpsr_pkg::NUM_SEQ];
  rpsr_pkg::seq_t                last_seq;
  logic [rpsr_pkg::SEQ_W:0]      successor;
  logic [rpsr_pkg::LANE_N-1:0]   match;
  rpsr_pkg::idx_t                start;
  logic                          in_take, drop, job_ready;
  rpsr_pkg::stats_t              stats_upd;
  rpsr_pkg::job_t                job;

  assign cfg_ready  = 1'b1;
  assign factor_nxt = (cfg_valid && cfg_ready) ? cfg_data : factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= rpsr_pkg::FACTOR_RESET;
    end else begin
      factor_r <= factor_nxt;
    end
  end

  always_comb begin
    if (factor_r == '0) begin
      f_eff = rpsr_pkg::FACTOR_W'(1);
    end else if (factor_r > rpsr_pkg::FACTOR_W'(rpsr_pkg::COPY_CAP)) begin
      f_eff = rpsr_pkg::FACTOR_W'(rpsr_pkg::COPY_CAP);
    end else begin
      f_eff = factor_r;
    end
  end

  assign fm1 = rpsr_pkg::IDX_W'(f_eff - rpsr_pkg::FACTOR_W'(1));

  assign seq[0] = in_seq_copy_0;
  assign seq[1] = in_seq_copy_1;
  assign seq[2] = in_seq_copy_2;
  assign seq[3] = in_seq_copy_3;
  assign seq[4] = in_seq_copy_4;
  assign seq[5] = in_seq_copy_5;
  assign seq[6] = in_seq_copy_6;
  assign seq[7] = in_seq_copy_7;

  assign successor = {1'b0, last_seq} + (rpsr_pkg::SEQ_W + 1)'(1);

  for (genvar j = 0; j < rpsr_pkg::LANE_N; j++) begin : g_lane
    rpsr_lane u_lane (
      .seq       (seq[j]),
      .successor (successor),
      .en        (rpsr_pkg::IDX_W'(j) < fm1),
      .match     (match[j])
    );
  end

  rpsr_merge u_merge (
    .match (match),
    .fm1   (fm1),
    .start (start)
  );

  assign in_ready = job_ready;
  assign in_take  = in_valid && in_ready;

  rpsr_stats u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_take),
    .seq0      (in_seq_copy_0),
    .start     (start),
    .last_seq  (last_seq),
    .drop      (drop),
    .stats_upd (stats_upd)
  );

  assign job.start = start;
  assign job.stats = stats_upd;

  rpsr_emit u_emit (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .job_valid              (in_valid && !drop),
    .job                    (job),
    .job_ready              (job_ready),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_copy_index         (out_copy_index),
    .out_last_of_run        (out_last_of_run),
    .out_total_count        (out_total_count),
    .out_lost_count         (out_lost_count),
    .out_out_of_order_count (out_out_of_order_count),
    .out_revived_count      (out_revived_count)
  );

endmodule
